[design/aht_pkg.sv]
// Package for the argmax hysteresis tracker: beat payload types, vector layout
// constants and register indexes. No dependencies.
package aht_pkg;

   // Vector layout (positions counted from zero within one vector)
   localparam logic [4:0] XBIN_COUNT    = 5'd9;
   localparam logic [3:0] SIZE_OFFSET   = 4'd9;
   localparam logic [4:0] SIZE_END      = 5'd13;   // SIZE_OFFSET + size group length
   localparam logic [3:0] VIS_POSITION  = 4'd13;
   localparam logic [4:0] VECTOR_LENGTH = 5'd14;

   localparam logic [7:0] CONFIRM_RESET = 8'd3;

   typedef enum logic [1:0] {
      CSR_ENTER_THRESHOLD = 2'd0,
      CSR_EXIT_THRESHOLD  = 2'd1,
      CSR_CONFIRM_COUNT   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] score;
      logic               last_score;
   } req_data_type;

   typedef struct packed {
      logic [3:0]         x_bin;
      logic [1:0]         size_bin;
      logic signed [31:0] vis_raw;
      logic               tracking;
   } rsp_data_type;

endpackage

[design/argmax_hysteresis_tracker.sv]
// Top level of the argmax hysteresis tracker: running argmax over one score
// vector, visibility debounce and tracking flag. Depends on aht_pkg.
//
// Usage:
//   req_*  : one signed score per beat, in vector order; last_score marks the
//            final beat of a vector. Positions are counted inside the block.
//   rsp_*  : one result beat per vector (x_bin, size_bin, vis_raw,
//            tracking), produced by the beat that carries last_score.
//   csr_*  : write-only registers (enter threshold, exit threshold, confirm
//            count), written while the block is idle. Unknown indexes are dropped.
// Output is registered: rsp shows the result in the cycle after the last beat of
//   a vector is accepted. Throughput, unless stalled: one score beat per cycle;
//   the argmax compare and last-beat debounce update land in the accepting cycle.
// Stall: the result sits in the output register; req_ready stays high while
//   that register is empty or being drained this cycle, and drops while a
//   result waits unaccepted, whether or not the next beat is a last one.
// Reset (synchronous, active high): accumulators, streak and tracking clear,
//   thresholds go to zero and confirm count to three; no result is pending.
module argmax_hysteresis_tracker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  aht_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output aht_pkg::rsp_data_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_addr,
   input  logic [31:0]           csr_wdata
);

   // configuration
   logic signed [31:0] enter_thr_ff;
   logic signed [31:0] exit_thr_ff;
   logic [7:0]         confirm_ff;

   // per-vector accumulators
   logic [3:0]         position_ff,   position_in;
   logic signed [31:0] best_x_val_ff, best_x_val_in;
   logic [3:0]         best_x_idx_ff, best_x_idx_in;
   logic signed [31:0] best_sz_val_ff, best_sz_val_in;
   logic [1:0]         best_sz_idx_ff, best_sz_idx_in;
   logic signed [31:0] vis_ff,        vis_in;

   // debounce state, kept across vectors
   logic [7:0]         streak_ff,     streak_in;
   logic               tracking_ff,   tracking_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   aht_pkg::rsp_data_type rsp_data_ff,  rsp_data_in;

   logic       accept;
   logic       in_x, in_size, in_vis;
   logic [3:0] size_k;
   logic [7:0] streak_upd;
   logic       track_upd;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enter_thr_ff <= '0;
         exit_thr_ff  <= '0;
         confirm_ff   <= aht_pkg::CONFIRM_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            aht_pkg::CSR_ENTER_THRESHOLD: enter_thr_ff <= csr_wdata;
            aht_pkg::CSR_EXIT_THRESHOLD:  exit_thr_ff  <= csr_wdata;
            aht_pkg::CSR_CONFIRM_COUNT:   confirm_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // group membership of the current position
   always_comb begin
      size_k  = position_ff - aht_pkg::SIZE_OFFSET;
      in_x    = ({1'b0, position_ff} < aht_pkg::VECTOR_LENGTH) &&
                ({1'b0, position_ff} < aht_pkg::XBIN_COUNT);
      in_size = ({1'b0, position_ff} < aht_pkg::VECTOR_LENGTH) &&
                (position_ff >= aht_pkg::SIZE_OFFSET) &&
                ({1'b0, position_ff} < aht_pkg::SIZE_END);
      in_vis  = ({1'b0, position_ff} < aht_pkg::VECTOR_LENGTH) &&
                (position_ff == aht_pkg::VIS_POSITION);
   end

   // accumulate this beat, then debounce and close the vector on last
   always_comb begin
      position_in    = position_ff;
      best_x_val_in  = best_x_val_ff;
      best_x_idx_in  = best_x_idx_ff;
      best_sz_val_in = best_sz_val_ff;
      best_sz_idx_in = best_sz_idx_ff;
      vis_in         = vis_ff;
      streak_in      = streak_ff;
      tracking_in    = tracking_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;
      streak_upd     = streak_ff;
      track_upd      = tracking_ff;

      if (accept) begin
         // first member of a group loads without compare; strict > keeps first max
         if (in_x && (position_ff == 4'd0 || req_data.score > best_x_val_ff)) begin
            best_x_val_in = req_data.score;
            best_x_idx_in = position_ff;
         end
         if (in_size && (size_k == 4'd0 || req_data.score > best_sz_val_ff)) begin
            best_sz_val_in = req_data.score;
            best_sz_idx_in = size_k[1:0];
         end
         if (in_vis) begin
            vis_in = req_data.score;
         end

         if (req_data.last_score) begin
            if (vis_in >= enter_thr_ff) begin
               if (streak_ff < confirm_ff) begin
                  streak_upd = streak_ff + 8'd1;
               end
            end else begin
               streak_upd = '0;
            end
            // hysteresis: drop below exit, pick up once streak is confirmed
            if (tracking_ff && (vis_in < exit_thr_ff)) begin
               track_upd = 1'b0;
            end else if (!tracking_ff && (streak_upd >= confirm_ff)) begin
               track_upd = 1'b1;
            end
            streak_in   = streak_upd;
            tracking_in = track_upd;

            rsp_valid_in         = 1'b1;
            rsp_data_in.x_bin    = best_x_idx_in;
            rsp_data_in.size_bin = best_sz_idx_in;
            rsp_data_in.vis_raw  = vis_in;
            rsp_data_in.tracking = track_upd;

            position_in    = '0;
            best_x_val_in  = '0;
            best_x_idx_in  = '0;
            best_sz_val_in = '0;
            best_sz_idx_in = '0;
            vis_in         = '0;
         end else begin
            position_in = position_ff + 4'd1;   // wraps 15 -> 0
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         best_x_val_ff  <= '0;
         best_x_idx_ff  <= '0;
         best_sz_val_ff <= '0;
         best_sz_idx_ff <= '0;
         vis_ff         <= '0;
         streak_ff      <= '0;
         tracking_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         position_ff    <= position_in;
         best_x_val_ff  <= best_x_val_in;
         best_x_idx_ff  <= best_x_idx_in;
         best_sz_val_ff <= best_sz_val_in;
         best_sz_idx_ff <= best_sz_idx_in;
         vis_ff         <= vis_in;
         streak_ff      <= streak_in;
         tracking_ff    <= tracking_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[tb/tb_top.sv]
// Self-checking bench for argmax_hysteresis_tracker: score vectors in, one frame
// result per vector out, checked against an in-bench model of the tracker.
// Depends on aht_pkg and the argmax_hysteresis_tracker RTL.
module tb_top;

   // Index that maps to no register; the block must drop writes to it.
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   localparam int PHASE_COUNT = 8;
   localparam int BEATS_PER_PHASE = 225;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   aht_pkg::req_data_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   aht_pkg::rsp_data_type rsp_data;
   logic                  csr_wr_en = 1'b0;
   logic [1:0]            csr_addr = '0;
   logic [31:0]           csr_wdata = '0;

   argmax_hysteresis_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run (~2k beats, heavy stalls).
   initial begin
      #5000000;
      $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Tracker model: running argmax, visibility latch, streak and
   // tracking flag, plus its own copy of the three registers.
   // ------------------------------------------------------------------
   logic [3:0]         vec_pos;
   logic signed [31:0] x_best_val;
   logic [3:0]         x_best_idx;
   logic signed [31:0] size_best_val;
   logic [3:0]         size_best_idx;   // kept wide; only 2 bits leave the block
   logic signed [31:0] vis_hold;
   logic [7:0]         streak_cnt;
   logic               track_on;
   logic signed [31:0] enter_lvl;
   logic signed [31:0] exit_lvl;
   logic [7:0]         confirm_need;

   aht_pkg::rsp_data_type frame_results_due[$];   // frames owed by the block, oldest first
   int                    errors = 0;
   int                    beats_sent = 0;
   int                    send_idle_pct = 0;
   int                    rsp_stall_pct = 0;

   function automatic void clear_vector();
      vec_pos       = '0;
      x_best_val    = '0;
      x_best_idx    = '0;
      size_best_val = '0;
      size_best_idx = '0;
      vis_hold      = '0;
   endfunction

   function automatic void reset_tracker();
      clear_vector();
      streak_cnt   = '0;
      track_on     = 1'b0;
      enter_lvl    = '0;
      exit_lvl     = '0;
      confirm_need = aht_pkg::CONFIRM_RESET;
   endfunction

   // Applies one accepted score beat; reports a frame when the beat is last.
   function automatic void advance_tracker(input aht_pkg::req_data_type beat,
                                           output bit emits,
                                           output aht_pkg::rsp_data_type frame);
      logic signed [31:0] s;
      logic [3:0]         k;
      s = beat.score;
      emits = 1'b0;
      frame = '0;
      // beats past the vector length touch no group, only their last mark counts
      if (vec_pos < aht_pkg::VECTOR_LENGTH) begin
         // first beat of a group loads without a compare; ties keep the older index
         if (vec_pos < aht_pkg::XBIN_COUNT && (vec_pos == 0 || s > x_best_val)) begin
            x_best_val = s;
            x_best_idx = vec_pos;
         end
         if (vec_pos >= aht_pkg::SIZE_OFFSET && vec_pos < aht_pkg::SIZE_END) begin
            k = vec_pos - aht_pkg::SIZE_OFFSET;
            if (k == 0 || s > size_best_val) begin
               size_best_val = s;
               size_best_idx = k;
            end
         end
         if (vec_pos == aht_pkg::VIS_POSITION) vis_hold = s;
      end
      if (!beat.last_score) begin
         vec_pos = vec_pos + 4'd1;   // 4-bit counter, wraps 15 -> 0
         return;
      end
      // debounce: streak saturates at the confirm count, any miss clears it
      if (vis_hold >= enter_lvl) begin
         if (streak_cnt < confirm_need) streak_cnt = streak_cnt + 8'd1;
      end else begin
         streak_cnt = '0;
      end
      if (track_on && vis_hold < exit_lvl) track_on = 1'b0;
      else if (!track_on && streak_cnt >= confirm_need) track_on = 1'b1;
      emits = 1'b1;
      frame.x_bin    = x_best_idx;
      frame.size_bin = size_best_idx[1:0];
      frame.vis_raw  = vis_hold;
      frame.tracking = track_on;
      clear_vector();
   endfunction

   // ------------------------------------------------------------------
   // Drivers. Inputs move on the falling edge; handshakes are sampled on
   // the rising edge, so the pre-edge values are seen.
   // ------------------------------------------------------------------

   // Offers one score beat and holds it until taken. A fixed frame, when
   // given, replaces the model's prediction for a beat that ends a vector.
   task automatic send_beat(input aht_pkg::req_data_type beat, input bit fixed,
                            input aht_pkg::rsp_data_type fixed_frame);
      bit                    emits;
      aht_pkg::rsp_data_type frame;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_tracker(beat, emits, frame);
      if (emits) frame_results_due.push_back(fixed ? fixed_frame : frame);
      beats_sent++;
   endtask

   // Drops valid and waits for every owed frame, then idles on so nothing is left
   // in flight before registers change.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         aht_pkg::CSR_ENTER_THRESHOLD: enter_lvl = value;
         aht_pkg::CSR_EXIT_THRESHOLD:  exit_lvl = value;
         aht_pkg::CSR_CONFIRM_COUNT:   confirm_need = value[7:0];
         default: ;
      endcase
   endtask

   // Receiver back-pressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // ------------------------------------------------------------------
   // Score generation
   // ------------------------------------------------------------------
   function automatic logic [31:0] any_score();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0;
         3, 4, 5: return $urandom_range(0, 20) - 10;   // dense ties
         default: return $urandom;
      endcase
   endfunction

   // Visibility beats hug a threshold half the time so both compares flip.
   function automatic logic [31:0] vis_score();
      logic [31:0] base;
      if ($urandom_range(0, 1)) return any_score();
      base = $urandom_range(0, 1) ? enter_lvl : exit_lvl;
      return base + $urandom_range(0, 6) - 3;
   endfunction

   // One random vector: mostly full length, some short, some overlong, some
   // running past 16 beats so the position counter wraps, and a little noise
   // with last marks scattered anywhere. Always ends on a last beat.
   task automatic send_vector();
      int                    shape;
      int                    len;
      bit                    mark;
      aht_pkg::req_data_type beat;
      shape = $urandom_range(0, 99);
      if (shape < 70) len = aht_pkg::VECTOR_LENGTH;
      else if (shape < 82) len = $urandom_range(1, aht_pkg::VECTOR_LENGTH - 1);
      else if (shape < 90) len = $urandom_range(aht_pkg::VECTOR_LENGTH + 1, 16);
      else if (shape < 96) len = 16 + $urandom_range(1, aht_pkg::VECTOR_LENGTH);
      else len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
         mark = (i == len - 1) || (shape >= 96 && $urandom_range(0, 3) == 0);
         beat.score      = ((i % 16) == aht_pkg::VIS_POSITION) ? vis_score() : any_score();
         beat.last_score = mark;
         send_beat(beat, 1'b0, '0);
      end
   endtask

   // ------------------------------------------------------------------
   // Directed rows
   // ------------------------------------------------------------------
   typedef struct {
      aht_pkg::req_data_type beat;
      bit                    fixed;
      aht_pkg::rsp_data_type want;
   } stim_row_type;

   stim_row_type directed_rows[$];

   function automatic void add_row(input logic [31:0] score, input logic mark,
                                   input bit fixed, input aht_pkg::rsp_data_type want);
      stim_row_type row;
      row.beat.score      = score;
      row.beat.last_score = mark;
      row.fixed           = fixed;
      row.want            = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void build_directed_rows();
      // lone last beat after reset: vis reads zero, streak 1 of 3, not tracking
      add_row(32'h0, 1'b1, 1'b1, '{4'd0, 2'd0, 32'h0, 1'b0});
      // lone minimum: loads at position 0 without compare; streak 2
      add_row(32'h8000_0000, 1'b1, 1'b1, '{4'd0, 2'd0, 32'h0, 1'b0});
      // full vector: x max tied at 3 and 8 (first wins), size max tied at 2 and 3,
      // max visibility makes streak reach 3 and tracking start
      add_row(-7, 1'b0, 1'b0, '0);
      add_row(32'h0, 1'b0, 1'b0, '0);
      add_row(32'h8000_0000, 1'b0, 1'b0, '0);
      add_row(32'h7FFF_FFFF, 1'b0, 1'b0, '0);
      add_row(1, 1'b0, 1'b0, '0);
      add_row(2, 1'b0, 1'b0, '0);
      add_row(3, 1'b0, 1'b0, '0);
      add_row(4, 1'b0, 1'b0, '0);
      add_row(32'h7FFF_FFFF, 1'b0, 1'b0, '0);
      add_row(32'h8000_0000, 1'b0, 1'b0, '0);
      add_row(-1, 1'b0, 1'b0, '0);
      add_row(5, 1'b0, 1'b0, '0);
      add_row(5, 1'b0, 1'b0, '0);
      add_row(32'h7FFF_FFFF, 1'b1, 1'b1, '{4'd3, 2'd2, 32'h7FFF_FFFF, 1'b1});
      // short vector, smaller second score: streak held at the cap
      add_row(32'h1234, 1'b0, 1'b0, '0);
      add_row(-3, 1'b1, 1'b0, '0);
   endfunction

   // Register plans per phase, extremes included.
   logic [31:0] enter_plan [PHASE_COUNT] = '{32'd0, -32'sd100, 32'h7FFF_FFFF, 32'h8000_0000,
                                            32'd50, 32'd0, 32'd1000, -32'sd1};
   logic [31:0] exit_plan [PHASE_COUNT]  = '{32'd0, -32'sd200, 32'h8000_0000, 32'h7FFF_FFFF,
                                            32'd100, -32'sd50, 32'd10, -32'sd1};
   logic [7:0]  confirm_plan [PHASE_COUNT] = '{8'd3, 8'd2, 8'd255, 8'd0,
                                              8'd1, 8'd5, 8'd8, 8'd3};

   // ------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------
   task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
   endtask

   always @(posedge clock) begin
      aht_pkg::rsp_data_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_results_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat: expected none, actual %p",
                     $time, rsp_data);
         end else begin
            want = frame_results_due.pop_front();
            if (rsp_data.x_bin !== want.x_bin)
               report("x_bin", 32'(want.x_bin), 32'(rsp_data.x_bin));
            if (rsp_data.size_bin !== want.size_bin)
               report("size_bin", 32'(want.size_bin), 32'(rsp_data.size_bin));
            if (rsp_data.vis_raw !== want.vis_raw)
               report("vis_raw", want.vis_raw, rsp_data.vis_raw);
            if (rsp_data.tracking !== want.tracking)
               report("tracking", 32'(want.tracking), 32'(rsp_data.tracking));
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int  phase_start;
      bit  paused;
      reset_tracker();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows run with reset register values and no idling
      build_directed_rows();
      foreach (directed_rows[i])
         send_beat(directed_rows[i].beat, directed_rows[i].fixed, directed_rows[i].want);

      paused = 1'b0;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         // registers change only with the block drained
         settle_block();
         write_reg(aht_pkg::CSR_ENTER_THRESHOLD, enter_plan[p]);
         write_reg(aht_pkg::CSR_EXIT_THRESHOLD, exit_plan[p]);
         write_reg(aht_pkg::CSR_CONFIRM_COUNT, {24'd0, confirm_plan[p]});
         if (p == 5) write_reg(CSR_UNMAPPED, $urandom);   // must change nothing
         @(negedge clock);
         csr_wr_en <= 1'b0;

         // idling cycles through none, sender gaps, receiver stalls, light both
         case (p % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 63; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 63; end
            default: begin send_idle_pct = 7; rsp_stall_pct = 7; end
         endcase

         phase_start = beats_sent;
         while (beats_sent - phase_start < BEATS_PER_PHASE) begin
            send_vector();
            // once, mid-phase under receiver stalls: hold off until all frames drain
            if (p == 2 && !paused && beats_sent - phase_start >= BEATS_PER_PHASE / 2) begin
               settle_block();
               paused = 1'b1;
            end
         end
      end

      settle_block();
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
